>>> hdl/slot_header_length_frame_parser_assert.svh
// assertion macros shared by the slot header frame parser checkers
// no dependencies; included by the checker file
`ifndef SLOT_HEADER_LENGTH_FRAME_PARSER_ASSERT_SVH
`define SLOT_HEADER_LENGTH_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SHLFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shlfp assertion failed");

// next-cycle implication, disabled while reset is high
`define SHLFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shlfp assertion failed");

`endif

>>> hdl/shlfp_pkg.sv
// shared constants and types of the slot header frame parser
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package shlfp_pkg;

   localparam int unsigned FRAME_BYTES_DEFAULT = 100;

   localparam logic [7:0] HDR_FIRST  = 8'h4D;
   localparam logic [7:0] HDR_THIRD  = 8'h54;
   localparam logic [7:0] DIGIT_BASE = 8'h30;

   localparam logic [2:0] ST_SEARCH   = 3'd0;
   localparam logic [2:0] ST_HEADER   = 3'd1;
   localparam logic [2:0] ST_BYTE     = 3'd2;
   localparam logic [2:0] ST_END      = 3'd3;
   localparam logic [2:0] ST_OVERSIZE = 3'd4;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  offset;
      logic [7:0]  data_byte;
      logic [7:0]  command;
      logic [15:0] payload_length;
      logic        frame_last;
   } result_type;

endpackage

>>> hdl/shlfp_parse.sv
// header search and frame tracking state of the slot header frame parser
// depends on shlfp_pkg
`timescale 1ns / 1ps

module shlfp_parse #(
   parameter int unsigned FRAME_BYTES = shlfp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             slot_id,
   output shlfp_pkg::result_type  result
);
   import shlfp_pkg::*;

   localparam int unsigned CNT_W     = $clog2(FRAME_BYTES);
   localparam logic [16:0] FRAME_LIM = 17'(FRAME_BYTES);

   logic [15:0]      window_ff, window_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             found_ff, found_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      len_ff, len_in;

   logic [7:0]       digit;
   logic [16:0]      frame_size;
   logic [16:0]      pos_next;
   logic             oversize;
   logic             frame_end;

   always_comb begin
      digit      = slot_id + DIGIT_BASE;
      window_in  = window_ff;
      count_in   = count_ff;
      found_in   = found_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      frame_size = 17'd0;
      pos_next   = 17'(count_ff) + 17'd1;
      oversize   = 1'b0;
      frame_end  = 1'b0;

      result.status         = ST_SEARCH;
      result.offset         = 7'(count_ff);
      result.data_byte      = rx_byte;
      result.command        = 8'd0;
      result.payload_length = 16'd0;
      result.frame_last     = 1'b0;

      if (!found_ff) begin
         if (count_ff < CNT_W'(2)) begin
            window_in = {window_ff[7:0], rx_byte};
            count_in  = count_ff + CNT_W'(1);
         end else if (window_ff[15:8] == HDR_FIRST && window_ff[7:0] == digit &&
                      rx_byte == HDR_THIRD) begin
            found_in      = 1'b1;
            count_in      = CNT_W'(3);
            result.status = ST_HEADER;
         end else begin
            // slide: drop the oldest byte, keep the other two
            window_in = {window_ff[7:0], rx_byte};
            count_in  = CNT_W'(2);
         end
      end else begin
         count_in      = count_ff + CNT_W'(1);
         result.status = ST_BYTE;
         if (count_ff == CNT_W'(3)) begin
            cmd_in = rx_byte;
         end else if (count_ff == CNT_W'(4)) begin
            len_in = {rx_byte, 8'h00};
         end else if (count_ff == CNT_W'(5)) begin
            len_in = len_ff | {8'h00, rx_byte};
         end
         if (count_ff >= CNT_W'(3)) begin
            result.command = cmd_in;
         end
         if (count_ff >= CNT_W'(5)) begin
            result.payload_length = len_in;
         end
         frame_size = {1'b0, len_in} + 17'd6;
         oversize   = (count_ff == CNT_W'(5)) && (frame_size > FRAME_LIM);
         frame_end  = (count_ff >= CNT_W'(5)) && (pos_next == frame_size);
         if (oversize) begin
            result.status = ST_OVERSIZE;
         end else if (frame_end) begin
            result.status     = ST_END;
            result.frame_last = 1'b1;
         end
         if (oversize || frame_end) begin
            window_in = 16'd0;
            count_in  = '0;
            found_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 16'd0;
         count_ff  <= '0;
         found_ff  <= 1'b0;
         cmd_ff    <= 8'd0;
         len_ff    <= 16'd0;
      end else if (step) begin
         window_ff <= window_in;
         count_ff  <= count_in;
         found_ff  <= found_in;
         cmd_ff    <= cmd_in;
         len_ff    <= len_in;
      end
   end

endmodule

>>> hdl/slot_header_length_frame_parser.sv
// slot header frame parser: input register, parse state and result register
// depends on shlfp_pkg and shlfp_parse
`timescale 1ns / 1ps

// Usage
//   req_* carries one received byte per beat (req_valid / req_stall).
//   rsp_* returns exactly one result beat per input beat, in order: status,
//   offset in the frame, the byte itself, held command and payload length,
//   and frame_last on the closing byte of a complete frame.
//   csr_write_enable / csr_write_data set the slot id; write it while idle.
// Pipeline and throughput
//   An accepted byte lands in the input register; when the result register
//   is free or being taken, the header/length logic runs on it and loads the
//   result register, which then presents the result beat. One byte per cycle
//   sustained while rsp_stall is low; the parse state updates once per byte.
// Reset
//   Synchronous, active high: both pipeline registers empty, parser back to
//   searching with an empty window, slot id zero.
// Stall
//   While rsp_stall holds a result, one more byte may still enter the input
//   register; after that req_stall rises until the result beat is taken.

module slot_header_length_frame_parser #(
   parameter int unsigned FRAME_BYTES = shlfp_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_offset,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_command,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_frame_last
);
   import shlfp_pkg::*;

   logic [7:0] slot_id_ff;
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff;
   result_type result;
   logic       advance;
   logic       accept;
   logic       step;

   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign step      = in_vld_ff && advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = advance ? step : rsp_vld_ff;
   end

   shlfp_parse #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .slot_id (slot_id_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_id_ff <= 8'd0;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            slot_id_ff <= csr_write_data;
         end
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_offset         = rsp_ff.offset;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_command        = rsp_ff.command;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_frame_last     = rsp_ff.frame_last;

endmodule

>>> hdl/shlfp_checker.sv
// port-level checks of the slot header frame parser, bound to the top level
// depends on shlfp_pkg and slot_header_length_frame_parser_assert.svh
`timescale 1ns / 1ps

`include "slot_header_length_frame_parser_assert.svh"

module shlfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [6:0]  rsp_offset,
   input logic [7:0]  rsp_data_byte,
   input logic [7:0]  rsp_command,
   input logic [15:0] rsp_payload_length,
   input logic        rsp_frame_last
);
   import shlfp_pkg::*;

   // frame_last marks exactly the frame end status
   `SHLFP_ASSERT_NOW(a_last_is_end, clock, reset, rsp_valid,
      rsp_frame_last == (rsp_status == ST_END))

   // a header match sits at offset 2 with nothing held yet
   `SHLFP_ASSERT_NOW(a_header_beat, clock, reset, rsp_valid && rsp_status == ST_HEADER,
      rsp_offset == 7'd2 && rsp_command == 8'd0 && rsp_payload_length == 16'd0)

   // search window never holds more than three bytes
   `SHLFP_ASSERT_NOW(a_search_offset, clock, reset, rsp_valid && rsp_status == ST_SEARCH,
      rsp_offset == 7'd0 || rsp_offset == 7'd1 || rsp_offset == 7'd2)

   // a stalled result beat holds
   `SHLFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data_byte) && $stable(rsp_status))

endmodule

bind slot_header_length_frame_parser shlfp_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_offset         (rsp_offset),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_command        (rsp_command),
   .rsp_payload_length (rsp_payload_length),
   .rsp_frame_last     (rsp_frame_last)
);
